>>> rtl/core/tsfd_pkg.sv
// Shared types and constants for the tyre sensor frame decoder.
// No dependencies; compile first.
package tsfd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CHAN_W    = 9;
  localparam int unsigned VALUE_W   = 29;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] PREAMBLE_BYTE = 8'hAA;

  localparam logic [11:0] PRESSURE_SCALE = 12'd2970;
  localparam logic signed [9:0] TEMP_OFFSET = 10'sd50;
  localparam logic signed [19:0] TEMP_SCALE = 20'sd1000;
  // floor(b * 184 / 10) == (b * 184 * 52429) >> 19 for every 8-bit b
  localparam logic [31:0] BATT_RECIP = 32'd9646936;
  localparam int unsigned BATT_SHIFT = 19;
  localparam logic [13:0] BATT_OFFSET = 14'd1730;

  localparam logic [BYTE_W-1:0] BAD_RX_CHANNEL   = 8'd4;
  localparam logic [BYTE_W-1:0] BAD_CALC_CHANNEL = 8'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_BASE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BATT_BASE     = 2'd2;

  localparam logic [BYTE_W-1:0] PRESSURE_BASE_RST = 8'd0;
  localparam logic [BYTE_W-1:0] TEMP_BASE_RST     = 8'd1;
  localparam logic [BYTE_W-1:0] BATT_BASE_RST     = 8'd2;

  // frame queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // message steps inside one frame
  localparam logic [1:0] STEP_FIRST  = 2'd0;
  localparam logic [1:0] STEP_SECOND = 2'd1;
  localparam logic [1:0] STEP_THIRD  = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0]   tyre;
    logic [2*BYTE_W-1:0] pressure;
    logic [BYTE_W-1:0]   temp;
    logic [BYTE_W-1:0]   batt;
    logic [BYTE_W-1:0]   rx_sum;
    logic [BYTE_W-1:0]   calc_sum;
    logic                ok;
  } frame_t;

  typedef struct packed {
    logic [BYTE_W-1:0] pressure_base;
    logic [BYTE_W-1:0] temp_base;
    logic [BYTE_W-1:0] batt_base;
  } cfg_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_TYRE = 7'b0000010,
    S_PLO  = 7'b0000100,
    S_PHI  = 7'b0001000,
    S_TEMP = 7'b0010000,
    S_BATT = 7'b0100000,
    S_CSUM = 7'b1000000
  } frame_state_t;

endpackage

>>> rtl/core/tsfd_in_if.sv
// Byte input channel: valid/ready handshake carrying one received byte.
// Depends on tsfd_pkg.
interface tsfd_in_if;
  logic                      valid;
  logic                      ready;
  logic [tsfd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/core/tsfd_out_if.sv
// Message output channel: valid/ready handshake carrying one telemetry message.
// Depends on tsfd_pkg.
interface tsfd_out_if;
  logic                                valid;
  logic                                ready;
  logic [tsfd_pkg::CHAN_W-1:0]         channel;
  logic signed [tsfd_pkg::VALUE_W-1:0] value;
  logic                                frame_ok;
  logic                                last;

  modport source (output valid, output channel, output value, output frame_ok,
                  output last, input ready);
  modport sink   (input valid, input channel, input value, input frame_ok,
                  input last, output ready);
endinterface

>>> rtl/core/tsfd_front.sv
// Front end: hunts for the preamble, collects frame bytes, pushes whole frames.
// Depends on tsfd_pkg.
module tsfd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          byte_valid,
  output logic                          byte_ready,
  input  logic [tsfd_pkg::BYTE_W-1:0]   rx_byte,
  output logic                          push_valid,
  input  logic                          push_ready,
  output tsfd_pkg::frame_t              push_frame
);
  import tsfd_pkg::*;

  frame_state_t      state_r, state_nxt;
  logic [BYTE_W-1:0] tyre_r, plo_r, phi_r, temp_r, batt_r, sum_r;
  logic              acc;

  assign byte_ready = push_ready;
  assign acc        = byte_valid && byte_ready;
  assign push_valid = acc && (state_r == S_CSUM);

  assign push_frame.tyre     = tyre_r;
  assign push_frame.pressure = {phi_r, plo_r};
  assign push_frame.temp     = temp_r;
  assign push_frame.batt     = batt_r;
  assign push_frame.rx_sum   = rx_byte;
  assign push_frame.calc_sum = sum_r;
  assign push_frame.ok       = (rx_byte == sum_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: state_nxt = (rx_byte == PREAMBLE_BYTE) ? S_TYRE : S_IDLE;
      S_TYRE: state_nxt = S_PLO;
      S_PLO:  state_nxt = S_PHI;
      S_PHI:  state_nxt = S_TEMP;
      S_TEMP: state_nxt = S_BATT;
      S_BATT: state_nxt = S_CSUM;
      S_CSUM: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else if (acc) begin
      state_r <= state_nxt;
    end
  end

  // frame bytes; the running sum restarts on the tyre byte
  always_ff @(posedge clk) begin
    if (acc) begin
      unique case (state_r)
        S_TYRE: begin
          tyre_r <= rx_byte;
          sum_r  <= rx_byte;
        end
        S_PLO: begin
          plo_r <= rx_byte;
          sum_r <= sum_r + rx_byte;
        end
        S_PHI: begin
          phi_r <= rx_byte;
          sum_r <= sum_r + rx_byte;
        end
        S_TEMP: begin
          temp_r <= rx_byte;
          sum_r  <= sum_r + rx_byte;
        end
        S_BATT: begin
          batt_r <= rx_byte;
          sum_r  <= sum_r + rx_byte;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/core/tsfd_queue.sv
// Two-entry frame queue decoupling the front end from the message back end.
// Depends on tsfd_pkg.
module tsfd_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  tsfd_pkg::frame_t push_frame,
  output logic             pop_valid,
  input  logic             pop,
  output tsfd_pkg::frame_t head
);
  import tsfd_pkg::*;

  frame_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;
  logic               do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/tsfd_back.sv
// Back end: walks one queued frame, scales each reading, registers one message a cycle unless stalled.
// Depends on tsfd_pkg.
module tsfd_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tsfd_pkg::cfg_t                      cfg,
  input  logic                                head_valid,
  input  tsfd_pkg::frame_t                    head,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tsfd_pkg::CHAN_W-1:0]         out_channel,
  output logic signed [tsfd_pkg::VALUE_W-1:0] out_value,
  output logic                                out_frame_ok,
  output logic                                out_last
);
  import tsfd_pkg::*;

  logic [1:0]                step_r, step_nxt;
  logic                      out_valid_r;
  logic [CHAN_W-1:0]         channel_r, channel_nxt;
  logic signed [VALUE_W-1:0] value_r, value_nxt;
  logic                      frame_ok_r, last_r, last_nxt;
  logic                      load;
  logic [BYTE_W-1:0]         base;
  logic [27:0]               pres_prod;
  logic signed [9:0]         temp_off;
  logic signed [19:0]        temp_prod;
  logic [31:0]               batt_prod;
  logic [13:0]               batt_val;

  assign load = head_valid && (!out_valid_r || out_ready);

  // final message: third for a good frame, second for a mismatch report
  assign last_nxt = head.ok ? (step_r == STEP_THIRD) : (step_r == STEP_SECOND);
  assign step_nxt = last_nxt ? STEP_FIRST : step_r + 1'b1;
  assign pop      = load && last_nxt;

  assign pres_prod = 28'(head.pressure) * 28'(PRESSURE_SCALE);
  assign temp_off  = $signed({2'b00, head.temp}) - TEMP_OFFSET;
  assign temp_prod = 20'(temp_off) * TEMP_SCALE;
  assign batt_prod = 32'(head.batt) * BATT_RECIP;
  assign batt_val  = 14'(batt_prod >> BATT_SHIFT) + BATT_OFFSET;

  always_comb begin
    base      = BAD_RX_CHANNEL;
    value_nxt = VALUE_W'($signed({1'b0, head.rx_sum}));
    if (head.ok) begin
      case (step_r)
        STEP_FIRST: begin
          base      = cfg.pressure_base;
          value_nxt = VALUE_W'($signed({1'b0, pres_prod}));
        end
        STEP_SECOND: begin
          base      = cfg.temp_base;
          value_nxt = VALUE_W'(temp_prod);
        end
        default: begin
          base      = cfg.batt_base;
          value_nxt = VALUE_W'($signed({1'b0, batt_val}));
        end
      endcase
    end else if (step_r != STEP_FIRST) begin
      base      = BAD_CALC_CHANNEL;
      value_nxt = VALUE_W'($signed({1'b0, head.calc_sum}));
    end
    channel_nxt = {1'b0, head.tyre} + {1'b0, base};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_FIRST;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        step_r <= step_nxt;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      channel_r  <= channel_nxt;
      value_r    <= value_nxt;
      frame_ok_r <= head.ok;
      last_r     <= last_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_channel  = channel_r;
  assign out_value    = value_r;
  assign out_frame_ok = frame_ok_r;
  assign out_last     = last_r;

`ifndef SYNTHESIS
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r != 2'd3)
    else $error("message step out of range");

  a_mismatch_two_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (head_valid && !head.ok) |-> (step_r == STEP_FIRST || step_r == STEP_SECOND))
    else $error("mismatch report ran past two messages");

  a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_valid_r && last_r))
    else $error("frame released without a last message");

  a_step_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (step_r == STEP_FIRST))
    else $error("step counter not restarted after frame");
`endif

endmodule

>>> rtl/core/tyre_sensor_frame_decoder.sv
// Top level of the tyre sensor frame decoder: config registers, front, queue, back.
// Depends on tsfd_pkg, tsfd_in_if, tsfd_out_if, tsfd_front, tsfd_queue, tsfd_back.
//
//   Port group  | Dir | Handshake        | Payload
//   ------------+-----+------------------+------------------------------------
//   in_chan     | in  | valid / ready    | rx_byte[7:0]
//   out_chan    | out | valid / ready    | channel[8:0], value[28:0] signed,
//               |     |                  | frame_ok, last
//   cfg_*       | in  | cfg_we           | cfg_index[1:0], cfg_wdata[7:0]
//
// One byte is taken per cycle; a byte that closes a frame is queued and the
// back end then releases one message per cycle (three for a good frame, two
// for a checksum mismatch), so the message register sets the rate.
// The first message is registered once the closing byte's frame has been queued and reaches the queue head.
// in_chan stalls only when both queue entries hold frames not yet released;
// out_chan stalls hold the message register and the queue head.
// Reset (rst_n low, synchronous) returns to preamble hunt, empties the queue
// and loads the channel bases 0, 1 and 2.
module tyre_sensor_frame_decoder (
  input  logic                             clk,
  input  logic                             rst_n,
  tsfd_in_if.sink                          in_chan,
  tsfd_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [tsfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tsfd_pkg::BYTE_W-1:0]      cfg_wdata
);
  import tsfd_pkg::*;

  logic [BYTE_W-1:0] pressure_base_r, temp_base_r, batt_base_r;
  cfg_t              cfg;

  logic              push_valid, push_ready;
  frame_t            push_frame;
  logic              head_valid, pop;
  frame_t            head;

  // Channel base registers; writes to an unused index drop silently.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressure_base_r <= PRESSURE_BASE_RST;
      temp_base_r     <= TEMP_BASE_RST;
      batt_base_r     <= BATT_BASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PRESSURE_BASE: pressure_base_r <= cfg_wdata;
        CFG_TEMP_BASE:     temp_base_r     <= cfg_wdata;
        CFG_BATT_BASE:     batt_base_r     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign cfg.pressure_base = pressure_base_r;
  assign cfg.temp_base     = temp_base_r;
  assign cfg.batt_base     = batt_base_r;

  // Front: frame the byte stream, push each completed frame.
  tsfd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_chan.valid),
    .byte_ready (in_chan.ready),
    .rx_byte    (in_chan.rx_byte),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_frame (push_frame)
  );

  // Queue: absorb a frame while the back end is still draining the previous one.
  tsfd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_frame (push_frame),
    .pop_valid  (head_valid),
    .pop        (pop),
    .head       (head)
  );

  // Back: scale readings and advance one message per accepted output slot.
  tsfd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .out_channel  (out_chan.channel),
    .out_value    (out_chan.value),
    .out_frame_ok (out_chan.frame_ok),
    .out_last     (out_chan.last)
  );

endmodule
